>>> design/afvl_pkg.sv
// Shared definitions for the aspect-fit viewport layout block.
// Widths, fixed-point constants, mode and register codes, inter-module structs.
// No dependencies.
`default_nettype none

package afvl_pkg;

	localparam int DIM_BITS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int ZOOM_W    = 24;
	localparam int DENS_W    = 24;
	localparam int CFG_W     = 24;
	localparam int IDX_W     = 2;

	localparam int RATIO_W = DIM_BITS + FRAC_BITS;
	localparam int PROD_W  = RATIO_W + ZOOM_W;
	localparam int K_W     = PROD_W - FRAC_BITS;
	localparam int LEN_W   = DIM_BITS + K_W;
	localparam int PHYS_W  = LEN_W + DENS_W;
	localparam int OUT_W   = 32;
	localparam int API_W   = 31;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 288;

	localparam logic [RATIO_W-1:0] ONE_Q = {{(RATIO_W-FRAC_BITS-1){1'b0}}, 1'b1,
		{FRAC_BITS{1'b0}}};
	localparam logic [OUT_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_STRETCH,
		MODE_FIT,
		MODE_FILL
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE,
		REG_DISP_W,
		REG_DISP_H,
		REG_DENSITY
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] rem;
		logic [RATIO_W-1:0]  nq;
	} divst_t;

	typedef struct packed {
		logic                vld;
		logic [RATIO_W-1:0]  rx;
		logic [RATIO_W-1:0]  ry;
		logic [DIM_BITS-1:0] sw;
		logic [DIM_BITS-1:0] sh;
		logic [ZOOM_W-1:0]   zoom;
	} ratio_t;

	typedef struct packed {
		logic             vld;
		logic [LEN_W-1:0] lw;
		logic [LEN_W-1:0] lh;
	} len_t;

	typedef struct packed {
		logic             vld;
		logic [OUT_W-1:0] vx;
		logic [OUT_W-1:0] vy;
		logic [OUT_W-1:0] vw;
		logic [OUT_W-1:0] vh;
	} phys_t;

endpackage

`default_nettype wire

>>> design/afvl_ratio.sv
// Pipelined restoring divider for the display-to-scene ratios of both axes.
// Two quotient bits per stage; carries the clamped scene sizes and zoom along.
// Depends on afvl_pkg.
`default_nettype none

module afvl_ratio (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [afvl_pkg::DIM_BITS-1:0] sw,
	input  logic [afvl_pkg::DIM_BITS-1:0] sh,
	input  logic [afvl_pkg::ZOOM_W-1:0]   zoom,
	input  logic [afvl_pkg::DIM_BITS-1:0] dw,
	input  logic [afvl_pkg::DIM_BITS-1:0] dh,
	output afvl_pkg::ratio_t              ratio
);
	import afvl_pkg::*;

	localparam int STEP_BITS = 2;
	localparam int STAGES    = RATIO_W / STEP_BITS;

	logic [STAGES:0]     vld_s;
	divst_t              dx_s   [STAGES+1];
	divst_t              dy_s   [STAGES+1];
	logic [DIM_BITS-1:0] sx_s   [STAGES+1];
	logic [DIM_BITS-1:0] sy_s   [STAGES+1];
	logic [ZOOM_W-1:0]   zoom_s [STAGES+1];

	logic [DIM_BITS-1:0] sw_c, sh_c;
	logic [ZOOM_W-1:0]   zoom_c;
	divst_t              dx_in, dy_in;

	function automatic divst_t div_step(input divst_t cur, input logic [DIM_BITS-1:0] den);
		divst_t            nxt;
		logic [DIM_BITS:0] trial;
		nxt = cur;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {nxt.rem, nxt.nq[RATIO_W-1]};
			if (trial >= {1'b0, den}) begin
				nxt.rem = DIM_BITS'(trial - {1'b0, den});
				nxt.nq  = {nxt.nq[RATIO_W-2:0], 1'b1};
			end else begin
				nxt.rem = trial[DIM_BITS-1:0];
				nxt.nq  = {nxt.nq[RATIO_W-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	always_comb begin
		sw_c      = (sw == '0) ? DIM_BITS'(1) : sw;
		sh_c      = (sh == '0) ? DIM_BITS'(1) : sh;
		zoom_c    = (zoom == '0) ? ZOOM_W'(ONE_Q) : zoom;
		dx_in.rem = '0;
		dx_in.nq  = {dw, {FRAC_BITS{1'b0}}} + RATIO_W'(sw_c >> 1);
		dy_in.rem = '0;
		dy_in.nq  = {dh, {FRAC_BITS{1'b0}}} + RATIO_W'(sh_c >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s[0]   <= dx_in;
			dy_s[0]   <= dy_in;
			sx_s[0]   <= sw_c;
			sy_s[0]   <= sh_c;
			zoom_s[0] <= zoom_c;
			for (int i = 1; i <= STAGES; i++) begin
				dx_s[i]   <= div_step(dx_s[i-1], sx_s[i-1]);
				dy_s[i]   <= div_step(dy_s[i-1], sy_s[i-1]);
				sx_s[i]   <= sx_s[i-1];
				sy_s[i]   <= sy_s[i-1];
				zoom_s[i] <= zoom_s[i-1];
			end
		end
	end

	assign ratio.vld  = vld_s[STAGES];
	assign ratio.rx   = dx_s[STAGES].nq;
	assign ratio.ry   = dy_s[STAGES].nq;
	assign ratio.sw   = sx_s[STAGES];
	assign ratio.sh   = sy_s[STAGES];
	assign ratio.zoom = zoom_s[STAGES];

endmodule

`default_nettype wire

>>> design/afvl_scale.sv
// Scale stages: mode selection, zoom multiply with rounding, and scene length.
// Five register stages; wide products split into partial products.
// Depends on afvl_pkg.
`default_nettype none

module afvl_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  afvl_pkg::mode_t  mode,
	input  afvl_pkg::ratio_t ratio,
	output afvl_pkg::len_t   len
);
	import afvl_pkg::*;

	localparam int KLO_W = 24;
	localparam int KHI_W = K_W - KLO_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [RATIO_W-1:0]        rx_s1, ry_s1;
	logic [DIM_BITS-1:0]       sw_s1, sh_s1, sw_s2, sh_s2, sw_s3, sh_s3;
	logic [ZOOM_W-1:0]         zoom_s1;
	logic [PROD_W-1:0]         px_s2, py_s2;
	logic [K_W-1:0]            kx_s3, ky_s3;
	logic [DIM_BITS+KLO_W-1:0] lxl_s4, lyl_s4;
	logic [DIM_BITS+KHI_W-1:0] lxh_s4, lyh_s4;
	logic [LEN_W-1:0]          lw_s5, lh_s5;

	logic [RATIO_W-1:0] rmin, rmax, rsx, rsy;
	logic [PROD_W-1:0]  pxr, pyr;

	always_comb begin
		rmin = (ratio.rx < ratio.ry) ? ratio.rx : ratio.ry;
		rmax = (ratio.rx > ratio.ry) ? ratio.rx : ratio.ry;
		case (mode)
			MODE_NONE: begin
				rsx = ONE_Q;
				rsy = ONE_Q;
			end
			MODE_STRETCH: begin
				rsx = ratio.rx;
				rsy = ratio.ry;
			end
			MODE_FIT: begin
				rsx = rmin;
				rsy = rmin;
			end
			MODE_FILL: begin
				rsx = rmax;
				rsy = rmax;
			end
			default: begin
				rsx = ratio.rx;
				rsy = ratio.ry;
			end
		endcase
		pxr = px_s2 + (PROD_W'(1) << (FRAC_BITS - 1));
		pyr = py_s2 + (PROD_W'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ratio.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1   <= rsx;
			ry_s1   <= rsy;
			sw_s1   <= ratio.sw;
			sh_s1   <= ratio.sh;
			zoom_s1 <= ratio.zoom;

			px_s2 <= rx_s1 * zoom_s1;
			py_s2 <= ry_s1 * zoom_s1;
			sw_s2 <= sw_s1;
			sh_s2 <= sh_s1;

			kx_s3 <= pxr[PROD_W-1:FRAC_BITS];
			ky_s3 <= pyr[PROD_W-1:FRAC_BITS];
			sw_s3 <= sw_s2;
			sh_s3 <= sh_s2;

			lxl_s4 <= sw_s3 * kx_s3[KLO_W-1:0];
			lxh_s4 <= sw_s3 * kx_s3[K_W-1:KLO_W];
			lyl_s4 <= sh_s3 * ky_s3[KLO_W-1:0];
			lyh_s4 <= sh_s3 * ky_s3[K_W-1:KLO_W];

			lw_s5 <= LEN_W'(lxl_s4) + {lxh_s4, {KLO_W{1'b0}}};
			lh_s5 <= LEN_W'(lyl_s4) + {lyh_s4, {KLO_W{1'b0}}};
		end
	end

	assign len.vld = v_s5;
	assign len.lw  = lw_s5;
	assign len.lh  = lh_s5;

endmodule

`default_nettype wire

>>> design/afvl_phys.sv
// Physical stages: centring offset, density multiply, rounding and saturation.
// Four register stages producing the viewport rectangle.
// Depends on afvl_pkg.
`default_nettype none

module afvl_phys (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  afvl_pkg::len_t                len,
	input  logic [afvl_pkg::DIM_BITS-1:0] dw,
	input  logic [afvl_pkg::DIM_BITS-1:0] dh,
	input  logic [afvl_pkg::DENS_W-1:0]   dens,
	output afvl_pkg::phys_t               phys
);
	import afvl_pkg::*;

	localparam int LSPLIT = LEN_W / 2;
	localparam int LHI_W  = LEN_W - LSPLIT;
	localparam int SZ_W   = PHYS_W - 2 * FRAC_BITS;
	localparam int OF_W   = PHYS_W - 2 * FRAC_BITS - 1;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [LEN_W-1:0]         lw_s1, lh_s1, mx_s1, my_s1;
	logic                     nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic [LSPLIT+DENS_W-1:0] swl_s2, shl_s2, oxl_s2, oyl_s2;
	logic [LHI_W+DENS_W-1:0]  swh_s2, shh_s2, oxh_s2, oyh_s2;
	logic [PHYS_W-1:0]        sw_s3, sh_s3, ox_s3, oy_s3;
	logic [OUT_W-1:0]         vx_s4, vy_s4, vw_s4, vh_s4;

	logic [LEN_W-1:0] fullx, fully;
	logic             negx, negy;

	function automatic logic [OUT_W-1:0] sat_size(input logic [PHYS_W-1:0] s);
		logic [SZ_W-1:0] hi;
		hi = s[PHYS_W-1:2*FRAC_BITS];
		return (hi > SZ_W'(POS_LIMIT)) ? POS_LIMIT : hi[OUT_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] sat_off(input logic [PHYS_W-1:0] s, input logic neg);
		logic [OF_W-1:0]  hi;
		logic [OUT_W-1:0] lim, mag;
		hi  = s[PHYS_W-1:2*FRAC_BITS+1];
		lim = neg ? NEG_LIMIT : POS_LIMIT;
		mag = (hi > OF_W'(lim)) ? lim : hi[OUT_W-1:0];
		return neg ? (OUT_W'(0) - mag) : mag;
	endfunction

	always_comb begin
		fullx = LEN_W'({dw, {FRAC_BITS{1'b0}}});
		fully = LEN_W'({dh, {FRAC_BITS{1'b0}}});
		negx  = len.lw > fullx;
		negy  = len.lh > fully;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= len.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_s1 <= len.lw;
			lh_s1 <= len.lh;
			nx_s1 <= negx;
			ny_s1 <= negy;
			mx_s1 <= negx ? (len.lw - fullx) : (fullx - len.lw);
			my_s1 <= negy ? (len.lh - fully) : (fully - len.lh);

			swl_s2 <= lw_s1[LSPLIT-1:0] * dens;
			swh_s2 <= lw_s1[LEN_W-1:LSPLIT] * dens;
			shl_s2 <= lh_s1[LSPLIT-1:0] * dens;
			shh_s2 <= lh_s1[LEN_W-1:LSPLIT] * dens;
			oxl_s2 <= mx_s1[LSPLIT-1:0] * dens;
			oxh_s2 <= mx_s1[LEN_W-1:LSPLIT] * dens;
			oyl_s2 <= my_s1[LSPLIT-1:0] * dens;
			oyh_s2 <= my_s1[LEN_W-1:LSPLIT] * dens;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;

			sw_s3 <= PHYS_W'(swl_s2) + {swh_s2, {LSPLIT{1'b0}}}
				+ (PHYS_W'(1) << (2 * FRAC_BITS - 1));
			sh_s3 <= PHYS_W'(shl_s2) + {shh_s2, {LSPLIT{1'b0}}}
				+ (PHYS_W'(1) << (2 * FRAC_BITS - 1));
			ox_s3 <= PHYS_W'(oxl_s2) + {oxh_s2, {LSPLIT{1'b0}}}
				+ (PHYS_W'(1) << (2 * FRAC_BITS));
			oy_s3 <= PHYS_W'(oyl_s2) + {oyh_s2, {LSPLIT{1'b0}}}
				+ (PHYS_W'(1) << (2 * FRAC_BITS));
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;

			vw_s4 <= sat_size(sw_s3);
			vh_s4 <= sat_size(sh_s3);
			vx_s4 <= sat_off(ox_s3, nx_s3);
			vy_s4 <= sat_off(oy_s3, ny_s3);
		end
	end

	assign phys.vld = v_s4;
	assign phys.vx  = vx_s4;
	assign phys.vy  = vy_s4;
	assign phys.vw  = vw_s4;
	assign phys.vh  = vh_s4;

endmodule

`default_nettype wire

>>> design/aspect_fit_viewport_layout_top.sv
// Aspect-fit viewport layout: one layout request in, one viewport beat out, every cycle
// in which the pipeline advances. A request passes through the ratio divider (an input stage
// and sixteen stages of two quotient bits each), the mode selection, zoom and scene scaling
// stages, the density multiply, rounding and saturation stages, and one output register. The
// pipeline advances as a whole whenever the output register is empty or being taken, so a new
// request is accepted in every such cycle. Configuration is written through the plain write
// port, by the user only while no request is in flight; the block does not enforce this. The
// scissor extent follows a display or density write via its product and extent registers.
// Depends on afvl_pkg, afvl_ratio, afvl_scale and afvl_phys.
`default_nettype none

module aspect_fit_viewport_layout_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [afvl_pkg::IDX_W-1:0]       cfg_index,
	input  logic [afvl_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// scn_w, scn_h, user_zoom
	input  logic [afvl_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// viewport_x, viewport_y, vp_w, vp_h, api_origin_y,
	// api_width, api_height, scissor_width, scissor_height, zero padding
	output logic [afvl_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import afvl_pkg::*;

	localparam int SCP_W = DIM_BITS + DENS_W;

	mode_t               mode_q;
	logic [DIM_BITS-1:0] dw_q, dh_q;
	logic [DENS_W-1:0]   dens_q;
	logic [DIM_BITS-1:0] dw_c, dh_c;

	logic   adv;
	ratio_t ratio;
	len_t   len;
	phys_t  phys;

	logic [SCP_W-1:0] scwp_q, schp_q;
	logic [SCP_W-1:0] scwr, schr;
	logic [API_W-1:0] scw_q, sch_q;

	logic             out_vld_q;
	logic [OUT_W-1:0] out_vx_q, out_vy_q, out_vw_q, out_vh_q, out_org_q;
	logic [API_W-1:0] out_aw_q, out_ah_q;
	logic [API_W-1:0] aw, ah;
	logic [OUT_W:0]   org_sum;
	logic [OUT_W-1:0] org;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			dw_q   <= DIM_BITS'(1);
			dh_q   <= DIM_BITS'(1);
			dens_q <= DENS_W'(ONE_Q);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:    mode_q <= mode_t'(cfg_wdata[1:0]);
				REG_DISP_W:  dw_q   <= cfg_wdata[DIM_BITS-1:0];
				REG_DISP_H:  dh_q   <= cfg_wdata[DIM_BITS-1:0];
				REG_DENSITY: dens_q <= cfg_wdata[DENS_W-1:0];
				default: ;
			endcase
		end
	end

	assign dw_c = (dw_q == '0) ? DIM_BITS'(1) : dw_q;
	assign dh_c = (dh_q == '0) ? DIM_BITS'(1) : dh_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	afvl_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (s_tvalid),
		.sw     (s_tdata[DIM_BITS-1:0]),
		.sh     (s_tdata[2*DIM_BITS-1:DIM_BITS]),
		.zoom   (s_tdata[2*DIM_BITS+ZOOM_W-1:2*DIM_BITS]),
		.dw     (dw_c),
		.dh     (dh_c),
		.ratio  (ratio)
	);

	afvl_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.mode   (mode_q),
		.ratio  (ratio),
		.len    (len)
	);

	afvl_phys u_phys (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.len    (len),
		.dw     (dw_c),
		.dh     (dh_c),
		.dens   (dens_q),
		.phys   (phys)
	);

	// scissor extent depends on configuration alone
	always_comb begin
		scwr = scwp_q + (SCP_W'(1) << (FRAC_BITS - 1));
		schr = schp_q + (SCP_W'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		scwp_q <= dw_c * dens_q;
		schp_q <= dh_c * dens_q;
		scw_q  <= (scwr[SCP_W-1:FRAC_BITS] == '0) ? API_W'(1) : API_W'(scwr[SCP_W-1:FRAC_BITS]);
		sch_q  <= (schr[SCP_W-1:FRAC_BITS] == '0) ? API_W'(1) : API_W'(schr[SCP_W-1:FRAC_BITS]);
	end

	always_comb begin
		aw      = (phys.vw == '0) ? API_W'(1) : phys.vw[API_W-1:0];
		ah      = (phys.vh == '0) ? API_W'(1) : phys.vh[API_W-1:0];
		org_sum = {phys.vy[OUT_W-1], phys.vy} + {2'b00, ah};
		org     = (!org_sum[OUT_W] && org_sum[OUT_W-1]) ? POS_LIMIT : org_sum[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= phys.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_vx_q  <= phys.vx;
			out_vy_q  <= phys.vy;
			out_vw_q  <= phys.vw;
			out_vh_q  <= phys.vh;
			out_org_q <= org;
			out_aw_q  <= aw;
			out_ah_q  <= ah;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, sch_q, scw_q, out_ah_q, out_aw_q, out_org_q,
		out_vh_q, out_vw_q, out_vy_q, out_vx_q};

	a_org_above: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(out_org_q) > $signed(out_vy_q)) || (out_org_q == POS_LIMIT)))
		else $error("flipped origin not above viewport y");

	a_api_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_aw_q != '0) &&
			((out_vw_q == '0) || (out_vw_q[API_W-1:0] == out_aw_q))))
		else $error("api width does not follow viewport width");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(phys.vld && adv) |=> m_tvalid)
		else $error("finished beat lost before output register");

	a_scissor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((scw_q != '0) && (sch_q != '0)))
		else $error("scissor extent is zero");

endmodule

`default_nettype wire
